// File: hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers for the base64 stream decoder
// Word formats, group job format, status codes and the alphabet decode.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // alphabet constants
  localparam logic [7:0] PadChar = 8'h3D;

  // group queue sizing
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_CHAR = 2'd2
  } status_e;

  // input word
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       run_last;
    logic       message_end;
  } out_word_t;

  // one finished group (or bad-length event) handed from front to back
  // emit[0] releases bytes[23:16], emit[1] bytes[15:8], emit[2] bytes[7:0]
  typedef struct packed {
    logic [23:0] bytes;
    logic [2:0]  emit;
    status_e     status;
    logic        msg_end;
  } job_t;

  // decoded character
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // map an ascii byte to its 6-bit value; pad maps to zero
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.val = 6'd62;
    end else if (c == 8'h2F) begin
      r.val = 6'd63;
    end else if (c == PadChar) begin
      r.val = 6'd0;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: character intake and group assembly
// Decodes each character, collects four sextets and pushes one job per
// finished group or per message that ends off a group boundary.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_word_t word_i,
  output logic     push_o,
  output job_t     job_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] acc_q, acc_d;
  logic        third_pad_q, third_pad_d;
  logic        bad_q, bad_d;
  sextet_t     sx;
  logic        is_pad;
  logic        bad_now;
  logic [23:0] full_val;

  assign sx       = sextet_of(word_i.char_code);
  assign is_pad   = (word_i.char_code == PadChar);
  assign bad_now  = bad_q | ~sx.ok;
  assign full_val = {acc_q, sx.val};

  // group state update and job generation
  always_comb begin
    pos_d       = pos_q;
    acc_d       = acc_q;
    third_pad_d = third_pad_q;
    bad_d       = bad_q;
    push_o      = 1'b0;
    job_o       = '{bytes: 24'd0, emit: 3'b001, status: ST_OK,
                    msg_end: word_i.end_of_input};
    if (take_i) begin
      if (pos_q != 2'd3) begin
        if (word_i.end_of_input) begin
          // message ends off a group boundary
          push_o      = 1'b1;
          job_o.status = ST_BAD_LEN;
          pos_d       = 2'd0;
          acc_d       = 18'd0;
          third_pad_d = 1'b0;
          bad_d       = 1'b0;
        end else begin
          acc_d = {acc_q[11:0], sx.val};
          pos_d = pos_q + 2'd1;
          bad_d = bad_now;
          if (pos_q == 2'd2) begin
            third_pad_d = is_pad;
          end
        end
      end else begin
        // fourth character closes the group
        push_o = 1'b1;
        if (bad_now) begin
          job_o.status = ST_BAD_CHAR;
        end else begin
          job_o.bytes = full_val;
          job_o.emit  = {~is_pad, ~third_pad_q, 1'b1};
        end
        pos_d       = 2'd0;
        acc_d       = 18'd0;
        third_pad_d = 1'b0;
        bad_d       = 1'b0;
      end
    end
  end

  // group registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      acc_q       <= 18'd0;
      third_pad_q <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      third_pad_q <= third_pad_d;
      bad_q       <= bad_d;
    end
  end

endmodule

// File: hw/rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue: short job queue between front and back
// Register-based fifo; head is visible without a read cycle.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output job_t head_o
);

  job_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign head_o  = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: result sequencer
// Walks the released bytes of the head job one per cycle, while the output is
// not stalled, into an output register and pops the job with its last result.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [2:0] done_q;
  logic [2:0] pending;
  logic [2:0] sel;
  logic       last;
  logic       load;
  logic [7:0] byte_sel;
  logic       out_valid_q;
  out_word_t  out_q;

  // pick the released byte still to go with the lowest emit bit
  assign pending = job_i.emit & ~done_q;
  always_comb begin
    if (pending[0]) begin
      sel      = 3'b001;
      byte_sel = job_i.bytes[23:16];
    end else if (pending[1]) begin
      sel      = 3'b010;
      byte_sel = job_i.bytes[15:8];
    end else begin
      sel      = 3'b100;
      byte_sel = job_i.bytes[7:0];
    end
  end
  assign last  = ((pending & ~sel) == 3'b000);
  assign load  = job_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last;

  // sequencing state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        done_q <= last ? 3'b000 : (done_q | sel);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.data_byte   <= (job_i.status == ST_OK) ? byte_sel : 8'd0;
      out_q.status      <= job_i.status;
      out_q.run_last    <= last;
      out_q.message_end <= last & job_i.msg_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: hw/rtl/base64_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit: streaming base64 decoder
// One character per word in; decoded bytes and error results out.
//
//   channel | valid      | stall       | word
//   --------+------------+-------------+-------------
//   in      | in_valid_i | in_stall_o  | in_word_i
//   out     | out_valid_o| out_stall_i | out_word_o
//
// Takes one character word per cycle while in_stall_o is low. A finished group
// leaves as up to three result words, one per cycle while out_stall_i is low,
// via a queue slot and the single output register of the back sequencer.
// A four-entry job queue parts intake from output; in_stall_o rises only
// while that queue is full. Reset clears group state, queue and output valid.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic take;
  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  logic q_full;
  job_t head;

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  // character intake
  b64d_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .word_i (in_word_i),
    .push_o (push),
    .job_o  (push_job)
  );

  // job queue
  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .head_o  (head)
  );

  // result sequencer
  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
